@@ rtl/tapc_pkg.sv @@
// Shared types, constants and arithmetic helpers for the tiled average predictor codec.
package tapc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DIM_W      = 13;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE         = 8'd0,
        REG_IMAGE_WIDTH  = 8'd1,
        REG_IMAGE_HEIGHT = 8'd2,
        REG_TILE_SIZE    = 8'd3
    } cfg_reg_t;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic                MODE_RESET   = MODE_ENCODE;
    localparam logic [DIM_W-1:0]    WIDTH_RESET  = 13'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1024;
    localparam logic [DIM_W-1:0]    TILE_RESET   = 13'd16;

    typedef struct packed {
        logic first_col;
        logic first_row;
        logic frame_end;
    } pos_flags_t;

    // floor((a + b) / 2) on two's complement operands
    function automatic logic [SAMPLE_W-1:0] half_sum(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b);
        logic signed [SAMPLE_W:0] sum;
        sum = $signed({a[SAMPLE_W-1], a}) + $signed({b[SAMPLE_W-1], b});
        return sum[SAMPLE_W:1];
    endfunction

endpackage

@@ rtl/tapc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tapc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tapc_pos.sv @@
// Raster and tile position counters, advanced once per accepted word.
module tapc_pos #(
    parameter int MAX_WIDTH = 4096,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           frame_start,
    input  logic [tapc_pkg::DIM_W-1:0]     image_width,
    input  logic [tapc_pkg::HEIGHT_W-1:0]  image_height,
    input  logic [tapc_pkg::DIM_W-1:0]     tile_size,
    output logic [CW-1:0]                  col,
    output tapc_pkg::pos_flags_t           flags
);

    localparam int CMP_W = (CW + 1 > tapc_pkg::DIM_W + 1) ? CW + 1 : tapc_pkg::DIM_W + 1;
    localparam int HW    = tapc_pkg::HEIGHT_W;
    localparam int TW    = tapc_pkg::DIM_W;

    logic [CW-1:0] cc_reg, cc_next, cc;
    logic [HW-1:0] rc_reg, rc_next, rc;
    logic [TW-1:0] tcp_reg, tcp_next, tcp;
    logic [TW-1:0] trp_reg, trp_next, trp;

    logic [CMP_W-1:0] w_eff, col_inc;
    logic [HW:0]      h_eff, rc_inc;
    logic [TW:0]      t_eff, tcp_inc, trp_inc;
    logic             row_end, frame_end;

    always_comb begin
        w_eff = (image_width == '0) ? CMP_W'(1) : CMP_W'(image_width);
        if (w_eff > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        h_eff = (image_height == '0) ? (HW+1)'(1) : {1'b0, image_height};
        t_eff = (tile_size == '0) ? (TW+1)'(1) : {1'b0, tile_size};
    end

    // frame_start restarts the counters for the word that carries it
    assign cc  = frame_start ? '0 : cc_reg;
    assign rc  = frame_start ? '0 : rc_reg;
    assign tcp = frame_start ? '0 : tcp_reg;
    assign trp = frame_start ? '0 : trp_reg;

    assign col_inc = CMP_W'(cc) + CMP_W'(1);
    assign rc_inc  = {1'b0, rc} + (HW+1)'(1);
    assign tcp_inc = {1'b0, tcp} + (TW+1)'(1);
    assign trp_inc = {1'b0, trp} + (TW+1)'(1);

    assign row_end   = col_inc >= w_eff;
    assign frame_end = row_end && (rc_inc >= h_eff);

    assign col             = cc;
    assign flags.first_col = (tcp == '0);
    assign flags.first_row = (trp == '0);
    assign flags.frame_end = frame_end;

    always_comb begin
        cc_next  = cc_reg;
        rc_next  = rc_reg;
        tcp_next = tcp_reg;
        trp_next = trp_reg;
        if (adv) begin
            if (row_end) begin
                cc_next  = '0;
                tcp_next = '0;
                if (frame_end) begin
                    rc_next  = '0;
                    trp_next = '0;
                end else begin
                    rc_next  = rc_inc[HW-1:0];
                    trp_next = (trp_inc >= t_eff) ? '0 : trp_inc[TW-1:0];
                end
            end else begin
                // cc + 1 < width <= MAX_WIDTH, so the low bits hold it
                cc_next  = col_inc[CW-1:0];
                rc_next  = rc;
                trp_next = trp;
                tcp_next = (tcp_inc >= t_eff) ? '0 : tcp_inc[TW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg  <= '0;
            rc_reg  <= '0;
            tcp_reg <= '0;
            trp_reg <= '0;
        end else begin
            cc_reg  <= cc_next;
            rc_reg  <= rc_next;
            tcp_reg <= tcp_next;
            trp_reg <= trp_next;
        end
    end

endmodule

@@ rtl/tapc_core.sv @@
// Input stage, line store, predictor and residual/reconstruction output register.
module tapc_core #(
    parameter int MAX_WIDTH = 4096,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [tapc_pkg::SAMPLE_W-1:0]      s_sample,
    input  logic [CW-1:0]                      in_col,
    input  tapc_pkg::pos_flags_t               in_flags,
    input  logic                               mode,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [tapc_pkg::SAMPLE_W-1:0]      m_value,
    output logic                               m_frame_end
);

    localparam int SW = tapc_pkg::SAMPLE_W;

    logic                 st_valid_reg, st_valid_next;
    logic [SW-1:0]        st_sample_reg;
    logic [CW-1:0]        st_col_reg;
    tapc_pkg::pos_flags_t st_flags_reg;
    logic                 fwd_hit_reg;
    logic [SW-1:0]        fwd_data_reg;
    logic [SW-1:0]        left_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [SW-1:0]        m_value_reg;
    logic                 m_frame_end_reg;

    logic          adv, go;
    logic [SW-1:0] ram_rdata, up, pred, orig, result;

    assign go      = st_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !st_valid_reg || go;
    assign adv     = s_valid && s_ready;

    tapc_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .aclk  (aclk),
        .we    (go),
        .waddr (st_col_reg),
        .wdata (orig),
        .re    (adv),
        .raddr (in_col),
        .rdata (ram_rdata)
    );

    // a write to the same column in the read cycle is not seen by the RAM read
    assign up = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    always_comb begin
        if (st_flags_reg.first_col) begin
            pred = st_flags_reg.first_row ? '0 : up;
        end else if (st_flags_reg.first_row) begin
            pred = left_reg;
        end else begin
            pred = tapc_pkg::half_sum(left_reg, up);
        end
        if (mode == tapc_pkg::MODE_DECODE) begin
            orig   = st_sample_reg + pred;
            result = orig;
        end else begin
            orig   = st_sample_reg;
            result = st_sample_reg - pred;
        end
    end

    always_comb begin
        st_valid_next = st_valid_reg;
        if (adv) begin
            st_valid_next = 1'b1;
        end else if (go) begin
            st_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            left_reg     <= '0;
        end else begin
            st_valid_reg <= st_valid_next;
            m_valid_reg  <= m_valid_next;
            if (adv) begin
                fwd_hit_reg <= go && (st_col_reg == in_col);
            end
            if (go) begin
                left_reg <= orig;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_sample_reg <= s_sample;
            st_col_reg    <= in_col;
            st_flags_reg  <= in_flags;
            fwd_data_reg  <= orig;
        end
        if (go) begin
            m_value_reg     <= result;
            m_frame_end_reg <= st_flags_reg.frame_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_value     = m_value_reg;
    assign m_frame_end = m_frame_end_reg;

endmodule

@@ rtl/tiled_average_predictor_codec.sv @@
// Top level of the tiled average predictor codec: config registers and datapath wiring.
//
// One word per clock in, one word per clock out while the output is not stalled; an
// accepted word is held in the input register, then in the output register. The line
// store's registered read is issued as the word is taken and lands together with the
// input register; once the output is free, the output register takes the prediction
// (add and halve) and the residual or reconstruction.
// The line store holds one row of original pixels (MAX_WIDTH entries) and is not
// cleared after reset, so the first frame must begin with frame_start and must not
// read above its first row before that row is written. Config words are always
// accepted and take effect for the next pixel; change them only between frames
// while the block is empty.
module tiled_average_predictor_codec #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [tapc_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                 s_frame_start,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [tapc_pkg::SAMPLE_W-1:0] m_value,
    output logic                                 m_frame_end,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tapc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tapc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                             mode_reg;
    logic [tapc_pkg::DIM_W-1:0]       width_reg;
    logic [tapc_pkg::HEIGHT_W-1:0]    height_reg;
    logic [tapc_pkg::DIM_W-1:0]       tile_reg;

    logic                             adv;
    logic [CW-1:0]                    col;
    tapc_pkg::pos_flags_t             flags;
    logic [tapc_pkg::SAMPLE_W-1:0]    value;

    assign cfg_ready = 1'b1;
    assign adv       = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= tapc_pkg::MODE_RESET;
            width_reg  <= tapc_pkg::WIDTH_RESET;
            height_reg <= tapc_pkg::HEIGHT_RESET;
            tile_reg   <= tapc_pkg::TILE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (tapc_pkg::cfg_reg_t'(cfg_index))
                tapc_pkg::REG_MODE:         mode_reg   <= cfg_data[0];
                tapc_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[tapc_pkg::DIM_W-1:0];
                tapc_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data[tapc_pkg::HEIGHT_W-1:0];
                tapc_pkg::REG_TILE_SIZE:    tile_reg   <= cfg_data[tapc_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    tapc_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .frame_start  (s_frame_start),
        .image_width  (width_reg),
        .image_height (height_reg),
        .tile_size    (tile_reg),
        .col          (col),
        .flags        (flags)
    );

    tapc_core #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .in_col      (col),
        .in_flags    (flags),
        .mode        (mode_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (value),
        .m_frame_end (m_frame_end)
    );

    assign m_value = $signed(value);

endmodule

@@ rtl/tapc_checker.sv @@
// Port-level checks for the tiled average predictor codec, bound to the top level.
module tapc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [tapc_pkg::SAMPLE_W-1:0]     m_value,
    input logic                              m_frame_end
);

    // no result word survives reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result word holds
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_frame_end))
        else $error("stalled result word changed");

    // with the output side empty the input side never stalls
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // an accepted word reaches the output once the output side then has room
    a_word_emerges: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 (!m_valid || m_ready) |=> m_valid)
        else $error("accepted word did not reach the output");

endmodule

bind tiled_average_predictor_codec tapc_checker u_tapc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_value     (m_value),
    .m_frame_end (m_frame_end)
);
